### design/lsh_pkg.sv
package lsh_pkg;

  localparam int FRAME_LEN = 5;
  localparam int CMD_DEPTH = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] CTRL_SET  = 8'h03;
  localparam logic [7:0] CTRL_UA   = 8'h07;

  localparam logic       RESET_ROLE          = 1'b1;
  localparam logic [5:0] RESET_TX_TIMEOUT    = 6'd3;
  localparam logic [5:0] RESET_RX_TIMEOUT    = 6'd18;
  localparam logic [2:0] RESET_ATTEMPT_LIMIT = 3'd3;
  localparam logic [7:0] RESET_ADDRESS       = 8'h03;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_LINK_UP  = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_BAD_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_TXWAIT = 2'd1,
    PH_RXWAIT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_ROLE          = 3'd0,
    REG_TX_TIMEOUT    = 3'd1,
    REG_RX_TIMEOUT    = 3'd2,
    REG_ATTEMPT_LIMIT = 3'd3,
    REG_ADDRESS       = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_UA_UP  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       role;
    logic [5:0] tx_timeout_ticks;
    logic [5:0] rx_timeout_ticks;
    logic [2:0] attempt_limit;
    logic [7:0] address_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] code;
  } cmd_t;

endpackage

### design/lsh_front.sv
module lsh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lsh_pkg::in_item_t item,
  input  lsh_pkg::cfg_t     cfg,
  output logic              cmd_push,
  output lsh_pkg::cmd_t     cmd
);

  lsh_pkg::phase_t phase, phase_next;
  logic       flag_seen, flag_seen_next;
  logic [2:0] capture_count, capture_count_next;
  logic [7:0] previous_byte, previous_byte_next;
  logic [5:0] idle_ticks, idle_ticks_next;
  logic [2:0] failed_attempts, failed_attempts_next;
  logic [7:0] captured_bytes [lsh_pkg::FRAME_LEN];

  logic       cap_we;
  logic [2:0] cap_idx;
  logic       fault;
  logic [1:0] fault_code;
  logic [7:0] exp_ctrl;
  logic       frame_match;
  logic [5:0] ticks_inc;
  logic [5:0] tick_limit;

  // closing flag arrives with four bytes already held
  assign exp_ctrl = (phase == lsh_pkg::PH_TXWAIT) ? lsh_pkg::CTRL_UA : lsh_pkg::CTRL_SET;
  assign frame_match = (capture_count == 3'(lsh_pkg::FRAME_LEN - 1)) &&
                       (captured_bytes[0] == lsh_pkg::FLAG_BYTE) &&
                       (captured_bytes[1] == cfg.address_byte) &&
                       (captured_bytes[2] == exp_ctrl) &&
                       (captured_bytes[3] == (cfg.address_byte ^ exp_ctrl));
  assign ticks_inc  = (idle_ticks != 6'd63) ? idle_ticks + 6'd1 : idle_ticks;
  assign tick_limit = (phase == lsh_pkg::PH_TXWAIT) ? cfg.tx_timeout_ticks
                                                    : cfg.rx_timeout_ticks;

  always_comb begin
    phase_next           = phase;
    flag_seen_next       = flag_seen;
    capture_count_next   = capture_count;
    previous_byte_next   = previous_byte;
    idle_ticks_next      = idle_ticks;
    failed_attempts_next = failed_attempts;
    cap_we     = 1'b0;
    cap_idx    = capture_count;
    fault      = 1'b0;
    fault_code = lsh_pkg::ST_TIMEOUT;
    cmd_push   = 1'b0;
    cmd.op     = lsh_pkg::CMD_SET;
    cmd.code   = lsh_pkg::ST_LINK_UP;

    if (accept) begin
      unique case (item.kind)
        lsh_pkg::KIND_START: begin
          flag_seen_next       = 1'b0;
          capture_count_next   = 3'd0;
          previous_byte_next   = 8'd0;
          idle_ticks_next      = 6'd0;
          failed_attempts_next = 3'd0;
          if (cfg.role) begin
            phase_next = lsh_pkg::PH_TXWAIT;
            cmd_push   = 1'b1;
            cmd.op     = lsh_pkg::CMD_SET;
          end else begin
            phase_next = lsh_pkg::PH_RXWAIT;
          end
        end
        lsh_pkg::KIND_BYTE: begin
          if (phase != lsh_pkg::PH_IDLE) begin
            idle_ticks_next = 6'd0;
            if (!flag_seen) begin
              // hunting for an opening flag
              if (item.rx_byte == lsh_pkg::FLAG_BYTE) begin
                flag_seen_next     = 1'b1;
                cap_we             = 1'b1;
                cap_idx            = 3'd0;
                capture_count_next = 3'd1;
              end
              previous_byte_next = item.rx_byte;
            end else if (item.rx_byte != lsh_pkg::FLAG_BYTE ||
                         previous_byte == lsh_pkg::FLAG_BYTE) begin
              if (item.rx_byte == lsh_pkg::FLAG_BYTE) begin
                // doubled flag restarts the frame
                cap_we             = 1'b1;
                cap_idx            = 3'd0;
                capture_count_next = 3'd1;
              end else begin
                cap_we = (capture_count < 3'(lsh_pkg::FRAME_LEN));
                if (capture_count != 3'd7) capture_count_next = capture_count + 3'd1;
              end
              previous_byte_next = item.rx_byte;
            end else begin
              cap_we = (capture_count < 3'(lsh_pkg::FRAME_LEN));
              if (capture_count != 3'd7) capture_count_next = capture_count + 3'd1;
              flag_seen_next     = 1'b0;
              previous_byte_next = 8'd0;
              if (frame_match) begin
                phase_next = lsh_pkg::PH_IDLE;
                cmd_push   = 1'b1;
                if (phase == lsh_pkg::PH_TXWAIT) begin
                  cmd.op   = lsh_pkg::CMD_STATUS;
                  cmd.code = lsh_pkg::ST_LINK_UP;
                end else begin
                  cmd.op   = lsh_pkg::CMD_UA_UP;
                end
              end else begin
                fault      = 1'b1;
                fault_code = lsh_pkg::ST_BAD_FRAME;
              end
            end
          end
        end
        lsh_pkg::KIND_TICK: begin
          if (phase != lsh_pkg::PH_IDLE) begin
            idle_ticks_next = ticks_inc;
            if (ticks_inc >= tick_limit) begin
              fault      = 1'b1;
              fault_code = lsh_pkg::ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase

      if (fault) begin
        flag_seen_next     = 1'b0;
        capture_count_next = 3'd0;
        previous_byte_next = 8'd0;
        idle_ticks_next    = 6'd0;
        if (failed_attempts >= cfg.attempt_limit) begin
          phase_next = lsh_pkg::PH_IDLE;
          cmd_push   = 1'b1;
          cmd.op     = lsh_pkg::CMD_STATUS;
          cmd.code   = fault_code;
        end else begin
          failed_attempts_next = failed_attempts + 3'd1;
          if (phase == lsh_pkg::PH_TXWAIT) begin
            cmd_push = 1'b1;
            cmd.op   = lsh_pkg::CMD_SET;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lsh_pkg::PH_IDLE;
      flag_seen       <= 1'b0;
      capture_count   <= 3'd0;
      previous_byte   <= 8'd0;
      idle_ticks      <= 6'd0;
      failed_attempts <= 3'd0;
    end else begin
      phase           <= phase_next;
      flag_seen       <= flag_seen_next;
      capture_count   <= capture_count_next;
      previous_byte   <= previous_byte_next;
      idle_ticks      <= idle_ticks_next;
      failed_attempts <= failed_attempts_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < lsh_pkg::FRAME_LEN; i++) begin
      if (cap_we && cap_idx == 3'(i)) captured_bytes[i] <= item.rx_byte;
    end
  end

endmodule

### design/lsh_cmd_fifo.sv
module lsh_cmd_fifo #(
  parameter int DEPTH = lsh_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  lsh_pkg::cmd_t wr_data,
  input  logic          rd,
  output lsh_pkg::cmd_t rd_data,
  output logic          full,
  output logic          nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsh_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_data;
  end

endmodule

### design/lsh_back.sv
module lsh_back (
  input  logic               clk,
  input  logic               rst,
  input  lsh_pkg::cfg_t      cfg,
  input  logic               cmd_ready,
  input  lsh_pkg::cmd_t      cmd,
  output logic               cmd_take,
  input  logic               pop,
  output logic               empty,
  output lsh_pkg::out_item_t result
);

  logic          busy;
  lsh_pkg::cmd_t cur;
  logic [2:0]    idx;
  logic [7:0]    ctrl;
  logic          done;

  assign ctrl = (cur.op == lsh_pkg::CMD_SET) ? lsh_pkg::CTRL_SET : lsh_pkg::CTRL_UA;
  assign empty = !busy;
  assign done  = busy && pop && result.last;
  assign cmd_take = cmd_ready && (!busy || done);

  always_comb begin
    result.is_status = 1'b0;
    result.tx_byte   = 8'd0;
    result.status    = lsh_pkg::ST_LINK_UP;
    result.last      = 1'b0;
    if (cur.op == lsh_pkg::CMD_STATUS) begin
      result.is_status = 1'b1;
      result.status    = cur.code;
      result.last      = 1'b1;
    end else if (idx == 3'(lsh_pkg::FRAME_LEN)) begin
      // link up report after the answering frame
      result.is_status = 1'b1;
      result.last      = 1'b1;
    end else begin
      case (idx)
        3'd0:    result.tx_byte = lsh_pkg::FLAG_BYTE;
        3'd1:    result.tx_byte = cfg.address_byte;
        3'd2:    result.tx_byte = ctrl;
        3'd3:    result.tx_byte = cfg.address_byte ^ ctrl;
        default: result.tx_byte = lsh_pkg::FLAG_BYTE;
      endcase
      result.last = (cur.op == lsh_pkg::CMD_SET) && (idx == 3'(lsh_pkg::FRAME_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (cmd_take) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && pop) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
  end

endmodule

### design/link_setup_set_ua_handshake.sv
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------
// input     | push / full        | item   (kind, rx_byte)
// results   | pop / empty        | result (is_status, tx_byte, status, last)
// config    | apb psel/penable   | paddr, pwdata, prdata, pready
//
// one input item is accepted per cycle while the command queue has room;
// the front updates the link state in that same cycle
// results leave the back sequencer one per cycle while pop is held; an
// item that opens or answers a frame yields 5 or 6 results; the queue holds
// commands while the output side stalls, and full rises when it is full
// synchronous reset sets config and control state, not the data registers
module link_setup_set_ua_handshake #(
  parameter int CMD_DEPTH = lsh_pkg::CMD_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  lsh_pkg::in_item_t          item,
  output logic                       empty,
  input  logic                       pop,
  output lsh_pkg::out_item_t         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lsh_pkg::ADDR_W-1:0] paddr,
  input  logic [lsh_pkg::DATA_W-1:0] pwdata,
  output logic [lsh_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  lsh_pkg::cfg_t cfg;
  logic          accept;
  logic          cmd_push;
  lsh_pkg::cmd_t cmd_in;
  lsh_pkg::cmd_t cmd_out;
  logic          cmd_take;
  logic          cmd_ready;
  logic          cfg_wr;
  logic [2:0]    reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];
  assign accept  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role             <= lsh_pkg::RESET_ROLE;
      cfg.tx_timeout_ticks <= lsh_pkg::RESET_TX_TIMEOUT;
      cfg.rx_timeout_ticks <= lsh_pkg::RESET_RX_TIMEOUT;
      cfg.attempt_limit    <= lsh_pkg::RESET_ATTEMPT_LIMIT;
      cfg.address_byte     <= lsh_pkg::RESET_ADDRESS;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lsh_pkg::REG_ROLE:          cfg.role             <= pwdata[0];
        lsh_pkg::REG_TX_TIMEOUT:    cfg.tx_timeout_ticks <= pwdata[5:0];
        lsh_pkg::REG_RX_TIMEOUT:    cfg.rx_timeout_ticks <= pwdata[5:0];
        lsh_pkg::REG_ATTEMPT_LIMIT: cfg.attempt_limit    <= pwdata[2:0];
        lsh_pkg::REG_ADDRESS:       cfg.address_byte     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lsh_pkg::REG_ROLE:          prdata = 32'(cfg.role);
      lsh_pkg::REG_TX_TIMEOUT:    prdata = 32'(cfg.tx_timeout_ticks);
      lsh_pkg::REG_RX_TIMEOUT:    prdata = 32'(cfg.rx_timeout_ticks);
      lsh_pkg::REG_ATTEMPT_LIMIT: prdata = 32'(cfg.attempt_limit);
      lsh_pkg::REG_ADDRESS:       prdata = 32'(cfg.address_byte);
      default:                    prdata = 32'd0;
    endcase
  end

  lsh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lsh_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (cmd_push),
    .wr_data  (cmd_in),
    .rd       (cmd_take),
    .rd_data  (cmd_out),
    .full     (full),
    .nonempty (cmd_ready)
  );

  lsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_out),
    .cmd_take  (cmd_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

### verif/link_setup_set_ua_handshake_checker.sv
module link_setup_set_ua_handshake_checker
  import lsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  in_item_t          item,
  input  logic              empty,
  input  logic              pop,
  input  out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                errors,
  output int                waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the link state and registers
  cfg_t       cfg;
  phase_t     link_phase;
  logic [1:0] flag_cnt;
  logic [7:0] cap [FRAME_LEN];
  logic [2:0] cap_cnt;
  logic [7:0] prev_b;
  logic [5:0] idle_t;
  logic [2:0] fails;

  out_item_t pending_results[$];

  task automatic note_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic clear_capture();
    flag_cnt = '0;
    cap_cnt  = '0;
    prev_b   = '0;
    idle_t   = '0;
  endtask

  task automatic reset_link();
    cfg.role             = RESET_ROLE;
    cfg.tx_timeout_ticks = RESET_TX_TIMEOUT;
    cfg.rx_timeout_ticks = RESET_RX_TIMEOUT;
    cfg.attempt_limit    = RESET_ATTEMPT_LIMIT;
    cfg.address_byte     = RESET_ADDRESS;
    link_phase = PH_IDLE;
    fails = '0;
    clear_capture();
    foreach (cap[i]) cap[i] = '0;
    pending_results.delete();
  endtask

  task automatic write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    case (reg_idx_t'(addr[ADDR_W-1:2]))
      REG_ROLE:          cfg.role = data[0];
      REG_TX_TIMEOUT:    cfg.tx_timeout_ticks = data[5:0];
      REG_RX_TIMEOUT:    cfg.rx_timeout_ticks = data[5:0];
      REG_ATTEMPT_LIMIT: cfg.attempt_limit = data[2:0];
      REG_ADDRESS:       cfg.address_byte = data[7:0];
      default: ;
    endcase
  endtask

  task automatic emit_byte(logic [7:0] b);
    out_item_t r;
    r = '0;
    r.tx_byte = b;
    pending_results.push_back(r);
  endtask

  task automatic emit_status(status_t s);
    out_item_t r;
    r = '0;
    r.is_status = 1'b1;
    r.status = s;
    pending_results.push_back(r);
  endtask

  task automatic emit_frame(logic [7:0] ctrl);
    emit_byte(FLAG_BYTE);
    emit_byte(cfg.address_byte);
    emit_byte(ctrl);
    emit_byte(cfg.address_byte ^ ctrl);
    emit_byte(FLAG_BYTE);
  endtask

  task automatic store_byte(logic [7:0] b);
    if (cap_cnt < 3'(FRAME_LEN)) cap[cap_cnt] = b;
    if (cap_cnt != 3'd7) cap_cnt++;
  endtask

  function automatic bit frame_matches(logic [7:0] ctrl);
    return cap_cnt == 3'(FRAME_LEN) && cap[0] == FLAG_BYTE &&
           cap[1] == cfg.address_byte && cap[2] == ctrl &&
           cap[3] == (cfg.address_byte ^ ctrl) && cap[4] == FLAG_BYTE;
  endfunction

  // timeout or bad frame: retry while under the limit, else give up
  task automatic link_fault(status_t code);
    clear_capture();
    if (fails >= cfg.attempt_limit) begin
      link_phase = PH_IDLE;
      emit_status(code);
    end else begin
      fails = fails + 3'd1;
      if (link_phase == PH_TXWAIT) emit_frame(CTRL_SET);
    end
  endtask

  task automatic advance_link(in_item_t it);
    int         size_at_entry;
    logic [7:0] b;
    logic [5:0] lim;
    out_item_t  tail;
    size_at_entry = pending_results.size();
    b = it.rx_byte;
    if (it.kind == KIND_START) begin
      clear_capture();
      fails = '0;
      if (cfg.role) begin
        link_phase = PH_TXWAIT;
        emit_frame(CTRL_SET);
      end else begin
        link_phase = PH_RXWAIT;
      end
    end else if (link_phase != PH_IDLE) begin
      case (it.kind)
        KIND_TICK: begin
          lim = (link_phase == PH_TXWAIT) ? cfg.tx_timeout_ticks : cfg.rx_timeout_ticks;
          if (idle_t != 6'd63) idle_t++;
          if (idle_t >= lim) link_fault(ST_TIMEOUT);
        end
        KIND_BYTE: begin
          idle_t = '0;
          if (flag_cnt == 2'd0) begin
            if (b == FLAG_BYTE) begin
              flag_cnt = 2'd1;
              cap_cnt = '0;
              store_byte(b);
            end
          end else if (b != FLAG_BYTE) begin
            store_byte(b);
          end else if (prev_b == FLAG_BYTE) begin
            // doubled flag opens a fresh frame
            cap_cnt = '0;
            store_byte(b);
          end else begin
            store_byte(b);
            flag_cnt = '0;
            if (link_phase == PH_TXWAIT) begin
              if (frame_matches(CTRL_UA)) begin
                link_phase = PH_IDLE;
                emit_status(ST_LINK_UP);
              end else begin
                link_fault(ST_BAD_FRAME);
              end
            end else begin
              if (frame_matches(CTRL_SET)) begin
                link_phase = PH_IDLE;
                emit_frame(CTRL_UA);
                emit_status(ST_LINK_UP);
              end else begin
                link_fault(ST_BAD_FRAME);
              end
            end
            b = '0;
          end
          prev_b = b;
        end
        default: ;
      endcase
    end
    if (pending_results.size() > size_at_entry) begin
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      note_mismatch($sformatf("result with no request pending: st=%0b tx=%h code=%0d last=%0b",
                              got.is_status, got.tx_byte, got.status, got.last));
    end else begin
      want = pending_results.pop_front();
      if (got.is_status !== want.is_status || got.tx_byte !== want.tx_byte ||
          got.status !== want.status || got.last !== want.last)
        note_mismatch($sformatf("got st=%0b tx=%h code=%0d last=%0b, want st=%0b tx=%h code=%0d last=%0b",
                                got.is_status, got.tx_byte, got.status, got.last,
                                want.is_status, want.tx_byte, want.status, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_link();
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (pop && !empty) check_result(result);
      if (push && !full) advance_link(item);
    end
    waiting = pending_results.size();
  end

endmodule

### verif/link_setup_set_ua_handshake_tb.sv
module link_setup_set_ua_handshake_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsh_pkg::*;

  localparam int         RANDOM_ITEMS = 410;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef enum int {
    FR_GOOD,
    FR_WRONG_CTRL,
    FR_FLIP,
    FR_LONG,
    FR_DOUBLE_FLAG,
    FR_NOISE
  } frame_mode_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              push    = 1'b0;
  in_item_t          item    = '0;
  logic              pop     = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic              full, empty, pready;
  out_item_t         result;
  logic [DATA_W-1:0] prdata;
  int                errors, waiting;

  bit         fast      = 1'b0;
  bit         long_hold = 1'b0;
  int         sent      = 0;
  int         cycle_cnt = 0;
  logic       cur_role;
  logic [5:0] cur_tx, cur_rx;
  logic [7:0] cur_addr;

  link_setup_set_ua_handshake dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  link_setup_set_ua_handshake_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .waiting(waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] kind, logic [7:0] b);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= {kind, b};
    push <= 1'b1;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  // psel stays up across back-to-back writes, the caller drops it
  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
  endtask

  task automatic reconfigure(logic role, logic [5:0] tx, logic [5:0] rx, logic [2:0] lim,
                             logic [7:0] addr);
    wait_drained();
    // let a request with no result settle before touching registers
    repeat (8) @(posedge clk);
    reg_write(REG_ROLE, DATA_W'(role));
    reg_write(REG_TX_TIMEOUT, DATA_W'(tx));
    reg_write(REG_RX_TIMEOUT, DATA_W'(rx));
    reg_write(REG_ATTEMPT_LIMIT, DATA_W'(lim));
    reg_write(REG_ADDRESS, DATA_W'(addr));
    psel   <= 1'b0;
    pwrite <= 1'b0;
    cur_role = role;
    cur_tx   = tx;
    cur_rx   = rx;
    cur_addr = addr;
  endtask

  task automatic send_frame(frame_mode_t mode);
    logic [7:0] ctrl;
    logic [7:0] fb[$];
    int         pos;
    ctrl = cur_role ? CTRL_UA : CTRL_SET;
    if (mode == FR_WRONG_CTRL) ctrl = cur_role ? CTRL_SET : CTRL_UA;
    fb = '{FLAG_BYTE, cur_addr, ctrl, cur_addr ^ ctrl, FLAG_BYTE};
    case (mode)
      FR_FLIP: begin
        pos = $urandom_range(0, 4);
        fb[pos] = fb[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      FR_LONG:        fb.insert($urandom_range(1, 4), 8'($urandom));
      FR_DOUBLE_FLAG: fb.push_front(FLAG_BYTE);
      FR_NOISE:       repeat ($urandom_range(1, 3)) fb.push_front(8'($urandom));
      default: ;
    endcase
    foreach (fb[i]) send_item(KIND_BYTE, fb[i]);
  endtask

  // start, then a few frame attempts with ticks in between
  task automatic run_episode();
    int frames, nt, lim, r;
    send_item(KIND_START, 8'($urandom));
    frames = $urandom_range(1, 3);
    repeat (frames) begin
      lim = cur_role ? cur_tx : cur_rx;
      nt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, lim + 1) : $urandom_range(0, 2);
      repeat (nt) send_item(KIND_TICK, 8'($urandom));
      r = $urandom_range(0, 9);
      send_frame(r < 5 ? FR_GOOD : frame_mode_t'(r - 4));
    end
  endtask

  initial begin : result_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        gap = 0;
      end else begin
        gap = fast ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin : stimulus
    int         phase_no, phase_end, random_start;
    logic       r_role;
    logic [5:0] r_tx, r_rx;
    logic [2:0] r_lim;
    logic [7:0] r_addr;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // transmitter at reset settings
    reconfigure(RESET_ROLE, RESET_TX_TIMEOUT, RESET_RX_TIMEOUT, RESET_ATTEMPT_LIMIT,
                RESET_ADDRESS);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_BYTE, FLAG_BYTE);
    send_item(KIND_UNUSED, 8'hff);
    send_item(KIND_START, 8'h00);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'hff);
    repeat (3) send_item(KIND_TICK, 8'h00);
    // doubled flag then a good UA
    send_item(KIND_BYTE, FLAG_BYTE);
    send_frame(FR_GOOD);

    // receiver with the tightest limits
    reconfigure(1'b0, 6'd63, 6'd1, 3'd0, 8'hff);
    send_item(KIND_START, 8'h00);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_START, 8'h00);
    send_frame(FR_WRONG_CTRL);
    send_item(KIND_START, 8'h00);
    send_frame(FR_GOOD);

    // fill the block while the result side holds off
    reconfigure(1'b1, 6'd3, 6'd18, 3'd3, 8'h5a);
    long_hold = 1'b1;
    fast = 1'b1;
    repeat (12) send_item(KIND_START, 8'($urandom));
    fast = 1'b0;

    random_start = sent;
    phase_no = 0;
    while (sent - random_start < RANDOM_ITEMS) begin
      r_role = $urandom_range(0, 1);
      case (phase_no % 4)
        0: begin
          r_tx = 6'd63; r_rx = 6'd63; r_lim = 3'd7; r_addr = 8'hff;
        end
        1: begin
          r_tx = 6'($urandom_range(0, 1)); r_rx = 6'($urandom_range(0, 1));
          r_lim = 3'd0; r_addr = 8'h00;
        end
        2: begin
          r_tx = 6'($urandom_range(1, 8)); r_rx = 6'($urandom_range(1, 8));
          r_lim = 3'($urandom_range(0, 7));
          r_addr = $urandom_range(0, 1) ? FLAG_BYTE : 8'($urandom);
        end
        default: begin
          r_tx = 6'($urandom); r_rx = 6'($urandom);
          r_lim = 3'($urandom); r_addr = 8'($urandom);
        end
      endcase
      reconfigure(r_role, r_tx, r_rx, r_lim, r_addr);
      fast = ($urandom_range(0, 3) == 0);
      phase_end = sent + 40;
      while (sent < phase_end) begin
        if ($urandom_range(0, 6) == 0) send_item(2'($urandom), 8'($urandom));
        else run_episode();
      end
      phase_no++;
    end
    fast = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
